>>> src/range_add_count_at_least_defines.svh
// ----------------------------------------------------------------------------
// range_add_count_at_least_defines
// Assertion macros for the range add / count-at-least block.
// ----------------------------------------------------------------------------
`ifndef RANGE_ADD_COUNT_AT_LEAST_DEFINES_SVH
`define RANGE_ADD_COUNT_AT_LEAST_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every clock outside reset
`define RACAL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("racal assertion failed");
// Check that a condition never holds outside reset
`define RACAL_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("racal forbidden condition");
`else
`define RACAL_ASSERT(lbl, prop)
`define RACAL_NEVER(lbl, expr)
`endif

`endif

>>> src/racal_pkg.sv
// ----------------------------------------------------------------------------
// racal_pkg
// Shared types and constants for the range add / count-at-least block.
// ----------------------------------------------------------------------------
package racal_pkg;

  localparam int DEPTH_DEF = 1024;
  localparam int DATA_W    = 32;
  localparam int IDX_W     = 10;
  localparam int CNT_W     = 11;
  localparam int LEN_W     = 11;
  localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_COUNT = 2'd2;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic clear;
    logic load_wr;
    logic rd;
    logic ex;
    logic publish;
  } ctl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic       clear_last;
    logic       at_last;
    logic       err;
    logic [1:0] op;
  } ctl_stat_t;

endpackage

>>> src/racal_ram.sv
// ----------------------------------------------------------------------------
// racal_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module racal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/racal_dp.sv
// ----------------------------------------------------------------------------
// racal_dp
// Datapath: element store, index walker, saturating adder, counter, result.
// ----------------------------------------------------------------------------
module racal_dp
  import racal_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ctl_cmd_t                 cmd,
  output ctl_stat_t                stat,
  input  logic                     cfg_wr_en,
  input  logic [LEN_W-1:0]         cfg_wr_data,
  input  logic [1:0]               in_cmd,
  input  logic [IDX_W-1:0]         in_first_index,
  input  logic [IDX_W-1:0]         in_last_index,
  input  logic signed [DATA_W-1:0] in_operand_value,
  output logic [CNT_W-1:0]         out_match_count,
  output logic                     out_range_error
);

  localparam int AW = $clog2(DEPTH);
  localparam int EW = AW + 1;
  localparam int CW = (EW > LEN_W) ? EW : LEN_W;

  logic [LEN_W-1:0]         len_r;
  logic [AW-1:0]            clr_r;
  logic [1:0]               op_r;
  logic [AW-1:0]            idx_r;
  logic [AW-1:0]            last_r;
  logic signed [DATA_W-1:0] opnd_r;
  logic [CNT_W-1:0]         cnt_r;
  logic                     err_r;
  logic [CNT_W-1:0]         res_cnt_r;
  logic                     res_err_r;

  logic [CW-1:0]            eff_len;
  logic [CW-1:0]            first_ext;
  logic [CW-1:0]            last_ext;
  logic                     err_nxt;
  logic signed [DATA_W-1:0] rd_data;
  logic signed [DATA_W:0]   sum;
  logic signed [DATA_W-1:0] sat_sum;
  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic [DATA_W-1:0]        wr_data;

  // Clamp length register to the store depth and range-check the item
  always_comb begin
    eff_len   = (CW'(len_r) > CW'(DEPTH)) ? CW'(DEPTH) : CW'(len_r);
    first_ext = CW'(in_first_index);
    last_ext  = CW'(in_last_index);
    unique case (in_cmd)
      CMD_LOAD:  err_nxt = (first_ext >= eff_len);
      CMD_ADD,
      CMD_COUNT: err_nxt = (first_ext > last_ext) || (last_ext >= eff_len);
      default:   err_nxt = 1'b0;
    endcase
  end

  // Saturating add of the element and amount
  always_comb begin
    sum = {rd_data[DATA_W-1], rd_data} + {opnd_r[DATA_W-1], opnd_r};
    if (sum[DATA_W] != sum[DATA_W-1]) begin
      sat_sum = sum[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      sat_sum = sum[DATA_W-1:0];
    end
  end

  // Select the store write
  always_comb begin
    wr_en   = cmd.clear || cmd.load_wr || (cmd.ex && (op_r == CMD_ADD));
    wr_addr = cmd.clear ? clr_r : idx_r;
    if (cmd.clear) begin
      wr_data = '0;
    end else if (cmd.load_wr) begin
      wr_data = opnd_r;
    end else begin
      wr_data = sat_sum;
    end
  end

  racal_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (cmd.rd),
    .rd_addr(idx_r),
    .rd_data(rd_data)
  );

  // Control state: length register and clear sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LEN_RESET;
      clr_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        len_r <= cfg_wr_data;
      end
      if (cmd.clear) begin
        clr_r <= clr_r + 1'b1;
      end
    end
  end

  // Capture item, walk indices, count matches, hold result
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_cmd;
      idx_r  <= AW'(in_first_index);
      last_r <= AW'(in_last_index);
      opnd_r <= in_operand_value;
      err_r  <= err_nxt;
      cnt_r  <= '0;
    end else if (cmd.ex) begin
      idx_r <= idx_r + 1'b1;
      if (op_r == CMD_COUNT && rd_data >= opnd_r) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
    if (cmd.publish) begin
      res_cnt_r <= cnt_r;
      res_err_r <= err_r;
    end
  end

  assign stat.clear_last = (clr_r == AW'(DEPTH - 1));
  assign stat.at_last    = (idx_r == last_r);
  assign stat.err        = err_r;
  assign stat.op         = op_r;

  assign out_match_count = res_cnt_r;
  assign out_range_error = res_err_r;

endmodule

>>> src/racal_ctrl.sv
// ----------------------------------------------------------------------------
// racal_ctrl
// Controller: clear sweep, command dispatch, element walk, result handoff.
// ----------------------------------------------------------------------------
module racal_ctrl
  import racal_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  ctl_stat_t stat,
  output ctl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_DISP,
    S_RD,
    S_EX,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || !out_stall;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_CLR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DISP;
        end
      end
      S_DISP: begin
        if (stat.err || (stat.op != CMD_LOAD && stat.op != CMD_ADD &&
                         stat.op != CMD_COUNT)) begin
          state_nxt = S_DONE;
        end else if (stat.op == CMD_LOAD) begin
          cmd.load_wr = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_EX;
      end
      S_EX: begin
        cmd.ex    = 1'b1;
        state_nxt = stat.at_last ? S_DONE : S_RD;
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.publish   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

>>> src/range_add_count_at_least.sv
// ----------------------------------------------------------------------------
// range_add_count_at_least
// Signed element store with load, saturating range add and range count.
// ----------------------------------------------------------------------------
//  channel  ports                                   handshake
//  in       cmd, first_index, last_index, operand   in_valid / in_stall
//  out      match_count, range_error                out_valid / out_stall
//  cfg      cfg_wr_data (length in use)             cfg_wr_en
//
// Each item is captured and dispatched; load and error items then go
// straight to the result, while add and count walk the range with one read
// and one execute step per element, since the store read is registered.
// After reset a clearing pass writes zero to all DEPTH entries while input
// is stalled. A new item is taken while a result waits.
// ----------------------------------------------------------------------------
module range_add_count_at_least
  import racal_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_cmd,
  input  logic [IDX_W-1:0]         in_first_index,
  input  logic [IDX_W-1:0]         in_last_index,
  input  logic signed [DATA_W-1:0] in_operand_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [CNT_W-1:0]         out_match_count,
  output logic                     out_range_error,
  input  logic                     cfg_wr_en,
  input  logic [LEN_W-1:0]         cfg_wr_data
);

`include "range_add_count_at_least_defines.svh"

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  racal_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  racal_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_cmd          (in_cmd),
    .in_first_index  (in_first_index),
    .in_last_index   (in_last_index),
    .in_operand_value(in_operand_value),
    .out_match_count (out_match_count),
    .out_range_error (out_range_error)
  );

  // Busy right after an item is taken
  `RACAL_ASSERT(a_busy_after_accept, in_valid && !in_stall |=> in_stall)
  // An errored result carries no count
  `RACAL_NEVER(a_err_no_count, out_valid && out_range_error && out_match_count != 0)
  // Count never exceeds the widest range
  `RACAL_NEVER(a_count_bound, out_valid && out_match_count > 11'd1024)

endmodule
